[rtl/fdem_pkg.sv]
// ---------------------------------------------------------------------------
// fdem_pkg
// Shared types and constants for the FAT directory entry matcher.
// ---------------------------------------------------------------------------
package fdem_pkg;

    localparam int unsigned PADDR_W  = 6;
    localparam int unsigned PDATA_W  = 64;
    localparam int unsigned REG_IDX_W = 3;

    // Register indexes (byte address is 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_NAME = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WHOLE_LEN   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEM_LEN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HAS_DOT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEARCH_EXT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_EXT_LEN     = 3'd5;

    localparam int unsigned NAME_BYTES = 8;
    localparam int unsigned EXT_BYTES  = 3;

    localparam logic [7:0] FREE_MARK     = 8'hE5;
    localparam logic [7:0] FREE_MARK_ALT = 8'h05;
    localparam logic [7:0] ATTR_LFN      = 8'h0F;
    localparam int unsigned ATTR_DIR_BIT = 4;

    typedef enum logic [1:0] {
        ST_SCAN    = 2'd0,
        ST_FOUND   = 2'd1,
        ST_MISSING = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef struct packed {
        logic        first_entry;
        logic [63:0] name_bytes;
        logic [23:0] ext_bytes;
        logic [7:0]  attribute;
        logic [15:0] cluster_high;
        logic [15:0] cluster_low;
        logic [31:0] entry_size;
        logic        last_entry;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] entry_cluster;
        logic [31:0] found_size;
        logic        is_directory;
    } t_out_item;

    typedef struct packed {
        logic [63:0] search_name;
        logic [3:0]  whole_len;
        logic [3:0]  stem_len;
        logic        has_dot;
        logic [23:0] search_ext;
        logic [1:0]  ext_len;
    } t_cfg;

endpackage

[rtl/fdem_cfg.sv]
// ---------------------------------------------------------------------------
// fdem_cfg
// APB-style register file holding the search name, extension, dot flag and compare lengths.
// ---------------------------------------------------------------------------
module fdem_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdem_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdem_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdem_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output fdem_pkg::t_cfg                o_cfg
);
    import fdem_pkg::*;

    t_cfg                 r_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign wr_en   = psel && penable && pwrite && pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SEARCH_NAME: r_cfg.search_name <= pwdata[63:0];
                REG_WHOLE_LEN:   r_cfg.whole_len   <= pwdata[3:0];
                REG_STEM_LEN:    r_cfg.stem_len    <= pwdata[3:0];
                REG_HAS_DOT:     r_cfg.has_dot     <= pwdata[0];
                REG_SEARCH_EXT:  r_cfg.search_ext  <= pwdata[23:0];
                REG_EXT_LEN:     r_cfg.ext_len     <= pwdata[1:0];
                default: ;  // unmapped: write dropped
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SEARCH_NAME: prdata = r_cfg.search_name;
            REG_WHOLE_LEN:   prdata = {60'd0, r_cfg.whole_len};
            REG_STEM_LEN:    prdata = {60'd0, r_cfg.stem_len};
            REG_HAS_DOT:     prdata = {63'd0, r_cfg.has_dot};
            REG_SEARCH_EXT:  prdata = {40'd0, r_cfg.search_ext};
            REG_EXT_LEN:     prdata = {62'd0, r_cfg.ext_len};
            default:         prdata = '0;
        endcase
    end

endmodule

[rtl/fdem_classify.sv]
// ---------------------------------------------------------------------------
// fdem_classify
// Classifies one directory entry against the search name and works out
// the result and the next finished mark.
// ---------------------------------------------------------------------------
module fdem_classify (
    input  fdem_pkg::t_cfg      i_cfg,
    input  fdem_pkg::t_in_item  i_item,
    input  logic                i_finished,
    output fdem_pkg::t_out_item o_result,
    output logic                o_finished
);
    import fdem_pkg::*;

    logic                  eff_finished;
    logic [7:0]            b0;
    logic [NAME_BYTES-1:0] name_eq;
    logic [NAME_BYTES-1:0] whole_mask;
    logic [NAME_BYTES-1:0] stem_mask;
    logic [EXT_BYTES-1:0]  ext_eq;
    logic [EXT_BYTES-1:0]  ext_mask;
    logic                  is_dir;
    logic                  whole_hit;
    logic                  file_hit;
    t_status               status;

    // Per-byte equality and length masks; lengths above 8 saturate naturally
    always_comb begin
        for (int i = 0; i < NAME_BYTES; i++) begin
            name_eq[i]    = i_cfg.search_name[8*i +: 8] == i_item.name_bytes[8*i +: 8];
            whole_mask[i] = i_cfg.whole_len > 4'(i);
            stem_mask[i]  = i_cfg.stem_len > 4'(i);
        end
        for (int j = 0; j < EXT_BYTES; j++) begin
            ext_eq[j]   = i_cfg.search_ext[8*j +: 8] == i_item.ext_bytes[8*j +: 8];
            ext_mask[j] = i_cfg.ext_len > 2'(j);
        end
    end

    assign b0           = i_item.name_bytes[7:0];
    assign is_dir       = i_item.attribute[ATTR_DIR_BIT];
    assign whole_hit    = &(name_eq | ~whole_mask);
    assign file_hit     = (&(name_eq | ~stem_mask)) && (&(ext_eq | ~ext_mask));
    assign eff_finished = i_finished && !i_item.first_entry;

    always_comb begin
        if (eff_finished) begin
            status = ST_IGNORED;
        end else if (b0 == 8'd0) begin
            status = ST_MISSING;
        end else if (b0 == FREE_MARK || b0 == FREE_MARK_ALT
                     || i_item.attribute == ATTR_LFN) begin
            status = i_item.last_entry ? ST_MISSING : ST_SCAN;
        end else if (is_dir) begin
            status = whole_hit ? ST_FOUND
                   : (i_item.last_entry ? ST_MISSING : ST_SCAN);
        end else if (!i_cfg.has_dot) begin
            status = ST_MISSING;
        end else begin
            status = file_hit ? ST_FOUND
                   : (i_item.last_entry ? ST_MISSING : ST_SCAN);
        end
    end

    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == ST_FOUND) begin
            o_result.entry_cluster = {i_item.cluster_high, i_item.cluster_low};
            o_result.found_size    = i_item.entry_size;
            o_result.is_directory  = is_dir;
        end
    end

    assign o_finished = eff_finished || (status != ST_SCAN);

endmodule

[rtl/fat_directory_entry_matcher.sv]
// ---------------------------------------------------------------------------
// fat_directory_entry_matcher
// Scans FAT directory entries, one per transfer, for an 8.3 search name
// and reports found / not found with the entry's cluster, size and type.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ------------------------------
//  in        sink       i_in_valid/o_in_stall  i_in_data  (t_in_item)
//  out       source     o_out_valid/i_out_stall o_out_data (t_out_item)
//  cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata
//
//  An entry passes from the input register through classify into the
//  result register; throughput is one entry per cycle while i_out_stall
//  is low, set by the single input register -> classify -> result register pass.
//  Reset (synchronous, active low) empties both stages, clears the
//  finished mark and all configuration registers.
//  A stall on the output holds the result register; the input stage keeps
//  taking a transfer until it too is full, then o_in_stall rises.
//
module fat_directory_entry_matcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // entry input
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fdem_pkg::t_in_item            i_in_data,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fdem_pkg::t_out_item           o_out_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fdem_pkg::PADDR_W-1:0]  paddr,
    input  logic [fdem_pkg::PDATA_W-1:0]  pwdata,
    output logic [fdem_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import fdem_pkg::*;

    t_cfg      cfg;

    // input stage
    logic      r_s1_valid;
    t_in_item  r_s1_data;
    // result stage
    logic      r_out_valid;
    t_out_item r_out_data;
    // scan state: set once a scan has ended
    logic      r_finished;

    t_out_item n_out_data;
    logic      n_finished;
    logic      out_load;   // result register free to take the next entry
    logic      s1_move;    // input stage hands its entry on
    logic      in_take;

    fdem_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    fdem_classify u_classify (
        .i_cfg      (cfg),
        .i_item     (r_s1_data),
        .i_finished (r_finished),
        .o_result   (n_out_data),
        .o_finished (n_finished)
    );

    assign out_load   = !r_out_valid || !i_out_stall;
    assign s1_move    = r_s1_valid && out_load;
    // input register is free when empty or emptying this cycle
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_data <= i_in_data;
        end
    end

    // finished mark moves only with the entry that decides it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finished <= 1'b0;
        end else if (s1_move) begin
            r_finished <= n_finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[rtl/fdem_checker.sv]
// ---------------------------------------------------------------------------
// fdem_checker
// Port-level checks for the FAT directory entry matcher, bound to the top.
// ---------------------------------------------------------------------------
module fdem_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  fdem_pkg::t_out_item           o_out_data,
    input  logic                          pready
);
    import fdem_pkg::*;

    // nothing comes out of a freshly reset pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    // only a found result carries entry data
    a_zero_unless_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_FOUND) |->
        (o_out_data.entry_cluster == 32'd0 && o_out_data.found_size == 32'd0
         && !o_out_data.is_directory))
        else $error("non-found result carries entry data");

    // an empty output stage never back-pressures the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid && $past(!o_out_valid)) |-> !o_in_stall)
        else $error("input stalled with empty pipeline");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

endmodule

bind fat_directory_entry_matcher fdem_checker u_fdem_checker (.*);
